/* sv/seg_isect_pkg.sv */
// Shared constants for the segment intersection test block.
`timescale 1ns / 1ps
package seg_isect_pkg;

    // Default coordinate width; the datapath supports 4 to 32 bits.
    localparam int COORD_BITS_DEFAULT = 16;

endpackage

/* sv/seg_isect_if.sv */
// Valid/ready channel interfaces for segment pairs in and test results out.
`timescale 1ns / 1ps
interface seg_isect_in_if #(
    parameter int COORD_BITS = seg_isect_pkg::COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_stop_x;
    logic signed [COORD_BITS-1:0] a_stop_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_stop_x;
    logic signed [COORD_BITS-1:0] b_stop_y;

    modport source (
        output valid, a_start_x, a_start_y, a_stop_x, a_stop_y,
               b_start_x, b_start_y, b_stop_x, b_stop_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_stop_x, a_stop_y,
               b_start_x, b_start_y, b_stop_x, b_stop_y,
        output ready
    );
endinterface

interface seg_isect_out_if;
    logic valid;
    logic ready;
    logic intersects;

    modport source (
        output valid, intersects,
        input  ready
    );
    modport sink (
        input  valid, intersects,
        output ready
    );
endinterface

/* sv/seg_isect_diff.sv */
// First pipeline stage: endpoint differences of both segments and the offset between their starts.
`timescale 1ns / 1ps
module seg_isect_diff #(
    parameter int COORD_BITS = seg_isect_pkg::COORD_BITS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    seg_isect_in_if.sink              i_seg,
    input  logic                      i_ready,
    output logic                      o_valid,
    output logic signed [COORD_BITS:0] o_dxa,
    output logic signed [COORD_BITS:0] o_dya,
    output logic signed [COORD_BITS:0] o_dxb,
    output logic signed [COORD_BITS:0] o_dyb,
    output logic signed [COORD_BITS:0] o_ex,
    output logic signed [COORD_BITS:0] o_ey
);
    localparam int DW = COORD_BITS + 1;

    logic                 r_valid;
    logic signed [DW-1:0] r_dxa, r_dya, r_dxb, r_dyb, r_ex, r_ey;
    logic signed [DW-1:0] n_dxa, n_dya, n_dxb, n_dyb, n_ex, n_ey;
    logic                 w_take;

    assign i_seg.ready = !r_valid || i_ready;
    assign w_take      = i_seg.valid && i_seg.ready;

    assign n_dxa = DW'(i_seg.a_start_x) - DW'(i_seg.a_stop_x);
    assign n_dya = DW'(i_seg.a_start_y) - DW'(i_seg.a_stop_y);
    assign n_dxb = DW'(i_seg.b_start_x) - DW'(i_seg.b_stop_x);
    assign n_dyb = DW'(i_seg.b_start_y) - DW'(i_seg.b_stop_y);
    // Offset from the start of B to the start of A, used by both parameters.
    assign n_ex  = DW'(i_seg.a_start_x) - DW'(i_seg.b_start_x);
    assign n_ey  = DW'(i_seg.a_start_y) - DW'(i_seg.b_start_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_seg.ready) begin
            r_valid <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_dxa <= n_dxa;
            r_dya <= n_dya;
            r_dxb <= n_dxb;
            r_dyb <= n_dyb;
            r_ex  <= n_ex;
            r_ey  <= n_ey;
        end
    end

    assign o_valid = r_valid;
    assign o_dxa   = r_dxa;
    assign o_dya   = r_dya;
    assign o_dxb   = r_dxb;
    assign o_dyb   = r_dyb;
    assign o_ex    = r_ex;
    assign o_ey    = r_ey;
endmodule

/* sv/seg_isect_mul.sv */
// Second pipeline stage: the six cross products of the differences.
`timescale 1ns / 1ps
module seg_isect_mul #(
    parameter int COORD_BITS = seg_isect_pkg::COORD_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [COORD_BITS:0]      i_dxa,
    input  logic signed [COORD_BITS:0]      i_dya,
    input  logic signed [COORD_BITS:0]      i_dxb,
    input  logic signed [COORD_BITS:0]      i_dyb,
    input  logic signed [COORD_BITS:0]      i_ex,
    input  logic signed [COORD_BITS:0]      i_ey,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic signed [2*COORD_BITS+1:0]  o_p_den0,
    output logic signed [2*COORD_BITS+1:0]  o_p_den1,
    output logic signed [2*COORD_BITS+1:0]  o_p_t0,
    output logic signed [2*COORD_BITS+1:0]  o_p_t1,
    output logic signed [2*COORD_BITS+1:0]  o_p_u0,
    output logic signed [2*COORD_BITS+1:0]  o_p_u1
);
    localparam int PW = 2 * COORD_BITS + 2;

    logic                 r_valid;
    logic signed [PW-1:0] r_p_den0, r_p_den1, r_p_t0, r_p_t1, r_p_u0, r_p_u1;
    logic signed [PW-1:0] n_p_den0, n_p_den1, n_p_t0, n_p_t1, n_p_u0, n_p_u1;

    assign o_ready = !r_valid || i_ready;

    assign n_p_den0 = i_dxa * i_dyb;
    assign n_p_den1 = i_dya * i_dxb;
    assign n_p_t0   = i_ex * i_dyb;
    assign n_p_t1   = i_ey * i_dxb;
    assign n_p_u0   = i_dya * i_ex;
    assign n_p_u1   = i_dxa * i_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_p_den0 <= n_p_den0;
            r_p_den1 <= n_p_den1;
            r_p_t0   <= n_p_t0;
            r_p_t1   <= n_p_t1;
            r_p_u0   <= n_p_u0;
            r_p_u1   <= n_p_u1;
        end
    end

    assign o_valid  = r_valid;
    assign o_p_den0 = r_p_den0;
    assign o_p_den1 = r_p_den1;
    assign o_p_t0   = r_p_t0;
    assign o_p_t1   = r_p_t1;
    assign o_p_u0   = r_p_u0;
    assign o_p_u1   = r_p_u1;
endmodule

/* sv/seg_isect_decide.sv */
// Last two pipeline stages: denominator and parameter numerators, then the range test.
`timescale 1ns / 1ps
module seg_isect_decide #(
    parameter int COORD_BITS = seg_isect_pkg::COORD_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [2*COORD_BITS+1:0]  i_p_den0,
    input  logic signed [2*COORD_BITS+1:0]  i_p_den1,
    input  logic signed [2*COORD_BITS+1:0]  i_p_t0,
    input  logic signed [2*COORD_BITS+1:0]  i_p_t1,
    input  logic signed [2*COORD_BITS+1:0]  i_p_u0,
    input  logic signed [2*COORD_BITS+1:0]  i_p_u1,
    seg_isect_out_if.source                 o_seg
);
    localparam int SW = 2 * COORD_BITS + 3;

    logic                 r_sum_valid;
    logic signed [SW-1:0] r_den, r_tn, r_un;
    logic signed [SW-1:0] n_den, n_tn, n_un;
    logic                 w_out_ready;
    logic                 r_out_valid;
    logic                 r_hit;
    logic                 n_hit;
    logic                 w_t_in, w_u_in;

    assign w_out_ready = !r_out_valid || o_seg.ready;
    assign o_ready     = !r_sum_valid || w_out_ready;

    assign n_den = SW'(i_p_den0) - SW'(i_p_den1);
    assign n_tn  = SW'(i_p_t0) - SW'(i_p_t1);
    assign n_un  = SW'(i_p_u0) - SW'(i_p_u1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (o_ready) begin
            r_sum_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_den <= n_den;
            r_tn  <= n_tn;
            r_un  <= n_un;
        end
    end

    // The crossing lies on both segments exactly when both line parameters
    // tn/den and un/den fall in [0, 1]; the bounds flip with the sign of den.
    always_comb begin
        if (r_den[SW-1]) begin
            w_t_in = (r_tn <= 0) && (r_tn >= r_den);
            w_u_in = (r_un <= 0) && (r_un >= r_den);
        end else begin
            w_t_in = (r_tn >= 0) && (r_tn <= r_den);
            w_u_in = (r_un >= 0) && (r_un <= r_den);
        end
        n_hit = (r_den != 0) && w_t_in && w_u_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sum_valid && w_out_ready) begin
            r_hit <= n_hit;
        end
    end

    assign o_seg.valid      = r_out_valid;
    assign o_seg.intersects = r_hit;
endmodule

/* sv/segment_intersection_test.sv */
// Top level of the segment intersection test pipeline.
`timescale 1ns / 1ps
// Takes one pair of segments per clock while no stage stalls and answers
// whether they meet, including touching at an endpoint; parallel, collinear
// and degenerate pairs always answer no. The test is exact: the crossing
// point is expressed as two line parameters over the common cross-product
// denominator and checked against [0, 1] by signed compares, with no division
// and no rounding. Throughput is one item per clock while the output is ready.
// There are four register stages: endpoint differences, cross products,
// denominator and numerator sums, and the range test with the output register.
// The accepting edge loads the first stage and each stage passes it on; a
// stage holds its item when it is full and the stage after it is not ready.
module segment_intersection_test #(
    parameter int COORD_BITS = seg_isect_pkg::COORD_BITS_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    seg_isect_in_if.sink    i_seg,
    seg_isect_out_if.source o_seg
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;

    logic                 w_diff_valid, w_diff_ready;
    logic signed [DW-1:0] w_dxa, w_dya, w_dxb, w_dyb, w_ex, w_ey;
    logic                 w_mul_valid, w_mul_ready;
    logic signed [PW-1:0] w_p_den0, w_p_den1, w_p_t0, w_p_t1, w_p_u0, w_p_u1;

    seg_isect_diff #(
        .COORD_BITS (COORD_BITS)
    ) u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (i_seg),
        .i_ready (w_diff_ready),
        .o_valid (w_diff_valid),
        .o_dxa   (w_dxa),
        .o_dya   (w_dya),
        .o_dxb   (w_dxb),
        .o_dyb   (w_dyb),
        .o_ex    (w_ex),
        .o_ey    (w_ey)
    );

    seg_isect_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_diff_valid),
        .o_ready  (w_diff_ready),
        .i_dxa    (w_dxa),
        .i_dya    (w_dya),
        .i_dxb    (w_dxb),
        .i_dyb    (w_dyb),
        .i_ex     (w_ex),
        .i_ey     (w_ey),
        .i_ready  (w_mul_ready),
        .o_valid  (w_mul_valid),
        .o_p_den0 (w_p_den0),
        .o_p_den1 (w_p_den1),
        .o_p_t0   (w_p_t0),
        .o_p_t1   (w_p_t1),
        .o_p_u0   (w_p_u0),
        .o_p_u1   (w_p_u1)
    );

    seg_isect_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mul_valid),
        .o_ready  (w_mul_ready),
        .i_p_den0 (w_p_den0),
        .i_p_den1 (w_p_den1),
        .i_p_t0   (w_p_t0),
        .i_p_t1   (w_p_t1),
        .i_p_u0   (w_p_u0),
        .i_p_u1   (w_p_u1),
        .o_seg    (o_seg)
    );
endmodule

/* verif/tb_segment_intersection_test.sv */
// Self-checking testbench for the segment intersection test block.
`timescale 1ns / 1ps
module tb_segment_intersection_test;
    import seg_isect_pkg::*;

    localparam int CW = COORD_BITS_DEFAULT;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [127:0]  t_wide;

    typedef struct packed {
        t_coord a_start_x;
        t_coord a_start_y;
        t_coord a_stop_x;
        t_coord a_stop_y;
        t_coord b_start_x;
        t_coord b_start_y;
        t_coord b_stop_x;
        t_coord b_stop_y;
    } t_seg_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    seg_isect_in_if #(.COORD_BITS(CW)) seg_in ();
    seg_isect_out_if                   seg_out ();

    segment_intersection_test #(.COORD_BITS(CW)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_in),
        .o_seg   (seg_out)
    );

    bit steady = 1'b0;
    bit expected_hits[$];
    int fail_count = 0;

    always #4 i_clk = ~i_clk;

    // Exact span test: num/den lies in [min(c1,c2), max(c1,c2)], den positive.
    function automatic bit within_span(t_wide num, t_wide den, t_wide c1, t_wide c2);
        t_wide lo;
        t_wide hi;
        lo = (c1 < c2) ? c1 : c2;
        hi = (c1 < c2) ? c2 : c1;
        return (num >= lo * den) && (num <= hi * den);
    endfunction

    function automatic bit segments_meet(t_seg_pair p);
        t_wide ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        t_wide dxa, dya, dxb, dyb, den, ca, cb, nx, ny;
        ax0 = p.a_start_x;
        ay0 = p.a_start_y;
        ax1 = p.a_stop_x;
        ay1 = p.a_stop_y;
        bx0 = p.b_start_x;
        by0 = p.b_start_y;
        bx1 = p.b_stop_x;
        by1 = p.b_stop_y;
        dxa = ax0 - ax1;
        dya = ay0 - ay1;
        dxb = bx0 - bx1;
        dyb = by0 - by1;
        den = dxa * dyb - dya * dxb;
        // Parallel, collinear and degenerate pairs never count as meeting.
        if (den == 0)
            return 1'b0;
        ca = ax0 * ay1 - ay0 * ax1;
        cb = bx0 * by1 - by0 * bx1;
        nx = ca * dxb - dxa * cb;
        ny = ca * dyb - dya * cb;
        if (den < 0) begin
            den = -den;
            nx  = -nx;
            ny  = -ny;
        end
        return within_span(nx, den, ax0, ax1) && within_span(nx, den, bx0, bx1) &&
               within_span(ny, den, ay0, ay1) && within_span(ny, den, by0, by1);
    endfunction

    function automatic t_seg_pair make_pair(int ax0, int ay0, int ax1, int ay1,
                                            int bx0, int by0, int bx1, int by1);
        t_seg_pair p;
        p.a_start_x = t_coord'(ax0);
        p.a_start_y = t_coord'(ay0);
        p.a_stop_x  = t_coord'(ax1);
        p.a_stop_y  = t_coord'(ay1);
        p.b_start_x = t_coord'(bx0);
        p.b_start_y = t_coord'(by0);
        p.b_stop_x  = t_coord'(bx1);
        p.b_stop_y  = t_coord'(by1);
        return p;
    endfunction

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_pair(t_seg_pair p);
        while (!steady && $urandom_range(99) < 38) begin
            seg_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        seg_in.valid     <= 1'b1;
        seg_in.a_start_x <= p.a_start_x;
        seg_in.a_start_y <= p.a_start_y;
        seg_in.a_stop_x  <= p.a_stop_x;
        seg_in.a_stop_y  <= p.a_stop_y;
        seg_in.b_start_x <= p.b_start_x;
        seg_in.b_start_y <= p.b_start_y;
        seg_in.b_stop_x  <= p.b_stop_x;
        seg_in.b_stop_y  <= p.b_stop_y;
        do
            @(posedge i_clk);
        while (!seg_in.ready);
        @(negedge i_clk);
    endtask

    task automatic test_crossing_basics();
        send_pair(make_pair(-10, -10, 10, 10, -10, 10, 10, -10));
        send_pair(make_pair(0, -5, 0, 5, -5, 0, 5, 0));
        send_pair(make_pair(10, 10, -10, -10, 10, -10, -10, 10));
        // Crossing at a non-integer point (1.5, 0.5).
        send_pair(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
        // Lines meet at (5, 5), outside both segments.
        send_pair(make_pair(0, 0, 1, 1, 10, 0, 9, 1));
        // Misses the other segment by one unit.
        send_pair(make_pair(0, 0, 10, 0, 5, 1, 5, 10));
    endtask

    task automatic test_parallel_and_degenerate();
        send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        // Collinear and overlapping still answers no.
        send_pair(make_pair(0, 0, 10, 10, 5, 5, 15, 15));
        send_pair(make_pair(0, 0, 10, 10, 20, 20, 30, 30));
        send_pair(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
        send_pair(make_pair(0, 0, 6, 6, 3, 3, 3, 3));
        send_pair(make_pair(7, -7, 7, -7, 7, -7, 7, -7));
    endtask

    task automatic test_endpoint_contact();
        send_pair(make_pair(0, 0, 10, 0, 10, 0, 10, 10));
        send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 7));
        send_pair(make_pair(-4, 3, 4, -3, 4, -3, 9, 8));
    endtask

    task automatic test_extreme_coords();
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, -32767, 32767, 32767));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, -32767, 32767, 32766));
        send_pair(make_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32767));
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(t_seg_pair'({4{32'h5555_AAAA}}));
        send_pair(t_seg_pair'({4{32'hAAAA_5555}}));
    endtask

    task automatic test_random_mix(input int count);
        int mode, px, py, ux, uy, wx, wy, sx, sy, k;
        int s1, s2, t1, t2;
        t_seg_pair p;
        repeat (count) begin
            mode = $urandom_range(99);
            if (mode < 20) begin
                p = t_seg_pair'({$urandom, $urandom, $urandom, $urandom});
            end else if (mode < 45) begin
                // A tight grid makes touching, collinear and parallel pairs common.
                p = make_pair(pick(-6, 6), pick(-6, 6), pick(-6, 6), pick(-6, 6),
                              pick(-6, 6), pick(-6, 6), pick(-6, 6), pick(-6, 6));
            end else if (mode < 75) begin
                // Both segments run through a common point.
                px = pick(-30000, 30000);
                py = pick(-30000, 30000);
                ux = pick(-200, 200);
                uy = pick(-200, 200);
                wx = pick(-200, 200);
                wy = pick(-200, 200);
                s1 = pick(0, 10);
                s2 = pick(0, 10);
                t1 = pick(0, 10);
                t2 = pick(0, 10);
                p = make_pair(px - ux * s1, py - uy * s1, px + ux * s2, py + uy * s2,
                              px - wx * t1, py - wy * t1, px + wx * t2, py + wy * t2);
            end else if (mode < 90) begin
                px = pick(-1000, 1000);
                py = pick(-1000, 1000);
                ux = pick(-2000, 2000);
                uy = pick(-2000, 2000);
                if ($urandom_range(1)) begin
                    k  = pick(-3, 3);
                    sx = k * ux;
                    sy = k * uy;
                end else begin
                    sx = pick(-15000, 15000);
                    sy = pick(-15000, 15000);
                end
                p = make_pair(px, py, px + ux, py + uy,
                              px + sx, py + sy, px + ux + sx, py + uy + sy);
            end else begin
                px = pick(-32768, 32767);
                py = pick(-32768, 32767);
                p = make_pair(px, py, px, py, pick(-32768, 32767), pick(-32768, 32767),
                              pick(-32768, 32767), pick(-32768, 32767));
                if ($urandom_range(1))
                    p = {p[4*CW-1:0], p[8*CW-1:4*CW]};
            end
            send_pair(p);
        end
    endtask

    task automatic test_back_to_back(input int count);
        steady = 1'b1;
        test_random_mix(count);
        steady = 1'b0;
    endtask

    always @(negedge i_clk)
        seg_out.ready <= steady || ($urandom_range(99) >= 38);

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n) begin
            if (seg_out.valid && seg_out.ready) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected result: intersects actual %0b", seg_out.intersects);
                    fail_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (seg_out.intersects !== want) begin
                        $error("intersects mismatch: expected %0b, actual %0b",
                               want, seg_out.intersects);
                        fail_count++;
                    end
                end
            end
            if (seg_in.valid && seg_in.ready)
                expected_hits.push_back(segments_meet('{seg_in.a_start_x, seg_in.a_start_y,
                                                      seg_in.a_stop_x, seg_in.a_stop_y,
                                                      seg_in.b_start_x, seg_in.b_start_y,
                                                      seg_in.b_stop_x, seg_in.b_stop_y}));
        end
    end

    initial begin
        seg_in.valid     = 1'b0;
        seg_in.a_start_x = '0;
        seg_in.a_start_y = '0;
        seg_in.a_stop_x  = '0;
        seg_in.a_stop_y  = '0;
        seg_in.b_start_x = '0;
        seg_in.b_start_y = '0;
        seg_in.b_stop_x  = '0;
        seg_in.b_stop_y  = '0;
        seg_out.ready    = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_crossing_basics();
        test_parallel_and_degenerate();
        test_endpoint_contact();
        test_extreme_coords();
        test_random_mix(400);
        test_back_to_back(200);
        test_random_mix(400);

        seg_in.valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(negedge i_clk);
        // The pipeline is four stages deep; give it room to show a stray result.
        repeat (16) @(negedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
